// ===== design/g3c_pkg.sv =====
package g3c_pkg;

  // Field widths of the request channels.
  localparam int PIX_W   = 16;
  localparam int SMO_W   = 18;
  localparam int COORD_W = 5;
  localparam int SIZE_W  = 6;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_TILE_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_CENTER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_EDGE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_CORNER = 2'd3;

  // Register values after reset.
  localparam logic [SIZE_W-1:0] TILE_SIZE_RST   = 6'd8;
  localparam logic [PIX_W-1:0]  COEF_CENTER_RST = 16'd13097;
  localparam logic [PIX_W-1:0]  COEF_EDGE_RST   = 16'd8047;
  localparam logic [PIX_W-1:0]  COEF_CORNER_RST = 16'd4944;

  // Arithmetic: a tap weight is a coefficient plus a folded coefficient.
  localparam int WEIGHT_W = PIX_W + 1;
  localparam int ACC_W    = 36;
  localparam int FRAC_W   = 16;
  localparam logic [ACC_W-FRAC_W-1:0] SAT_MAX = 20'd262143;

  // Three line stores, one per kernel row.
  localparam int NUM_LINES = 3;
  localparam int LINE_W    = 2;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
  } pixel_req_t;

  typedef struct packed {
    logic [SMO_W-1:0]   smoothed;
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_col;
    logic               last;
  } result_t;

  // Control of the shared multiply-accumulate unit.
  typedef struct packed {
    logic en;
    logic first;
  } mac_ctrl_t;

endpackage

// ===== design/g3c_stream_if.sv =====
interface g3c_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/g3c_ram.sv =====
module g3c_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 96
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/g3c_mac.sv =====
module g3c_mac (
  input  logic                     clk,
  input  g3c_pkg::mac_ctrl_t       ctrl,
  input  logic [g3c_pkg::WEIGHT_W-1:0] weight,
  input  logic [g3c_pkg::PIX_W-1:0]    sample,
  output logic [g3c_pkg::ACC_W-1:0]    acc
);
  import g3c_pkg::*;

  logic [WEIGHT_W+PIX_W-1:0] product;

  assign product = weight * sample;

  // The first tap of an output starts a fresh sum.
  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      if (ctrl.first) begin
        acc <= ACC_W'(product);
      end else begin
        acc <= acc + ACC_W'(product);
      end
    end
  end
endmodule

// ===== design/gaussian_3x3_edge_folding_convolver_core.sv =====
// 3x3 smoothing filter for a square tile, with the left and right spill
// folded back into the border columns.
// Pixels arrive on the pixels channel in raster order, one request per
// pixel, as unsigned Q0.16 values. Results leave on the results channel,
// one request per output pixel, with its row, column and a last flag on
// the final result caused by one input pixel.
// Every pixel is written to the line store at its position. A pixel that ends
// row r (r >= 1) starts the output of row r-1; the pixel that ends the tile
// starts rows N-2 and N-1. For each output pixel, nine taps are read one by
// one from the line store RAM and summed on the single shared
// multiply-accumulate unit; a drain state lets the last tap settle and a
// put state loads the output register. The pixels channel is not ready
// while rows are being output. The output register holds a result until
// it is taken; while the receiver stalls, the sequencer waits with the
// next result. Reset clears the position to the start of a tile and loads
// the register defaults; the line store is not cleared. The user must make
// configuration writes through write_en, write_index and write_data only
// while the block idles; the block itself does not enforce this.
module gaussian_3x3_edge_folding_convolver_core #(
  parameter int MAX_TILE = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             write_en,
  input  logic [g3c_pkg::CFG_IDX_W-1:0]    write_index,
  input  logic [g3c_pkg::CFG_DATA_W-1:0]   write_data,
  g3c_stream_if.sink                       pixels,
  g3c_stream_if.source                     results
);
  import g3c_pkg::*;

  localparam int DEPTH  = NUM_LINES * MAX_TILE;
  localparam int ADDR_W = $clog2(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_DRAIN,
    S_PUT
  } state_t;

  state_t state;

  // Configuration registers.
  logic [SIZE_W-1:0] tile_size;
  logic [PIX_W-1:0]  coef_center;
  logic [PIX_W-1:0]  coef_edge;
  logic [PIX_W-1:0]  coef_corner;

  // Input position.
  logic [COORD_W-1:0] in_row;
  logic [COORD_W-1:0] in_col;
  logic [LINE_W-1:0]  in_line;

  // Output position and taps.
  logic [COORD_W-1:0] em_row;
  logic [COORD_W-1:0] em_col;
  logic [LINE_W-1:0]  em_line;
  logic               em_more;
  logic [1:0]         tap_dr;
  logic [1:0]         tap_dc;

  // Tap waiting for its RAM data.
  logic                tap_v;
  logic                tap_first;
  logic                tap_ok;
  logic [WEIGHT_W-1:0] tap_w;

  logic    out_valid;
  result_t out_data;

  function automatic logic [LINE_W-1:0] line_next(input logic [LINE_W-1:0] l);
    return (l == LINE_W'(NUM_LINES - 1)) ? '0 : l + 1'b1;
  endfunction

  function automatic logic [LINE_W-1:0] line_prev(input logic [LINE_W-1:0] l);
    return (l == '0) ? LINE_W'(NUM_LINES - 1) : l - 1'b1;
  endfunction

  // Effective tile size, clamped to the supported range.
  logic [SIZE_W-1:0] n;
  always_comb begin
    if (tile_size < SIZE_W'(2)) begin
      n = SIZE_W'(2);
    end else if (tile_size > SIZE_W'(MAX_TILE)) begin
      n = SIZE_W'(MAX_TILE);
    end else begin
      n = tile_size;
    end
  end

  // Position of the accepted pixel; a position outside the tile restarts it.
  logic               in_fire;
  logic               restart;
  logic [COORD_W-1:0] cur_row;
  logic [COORD_W-1:0] cur_col;
  logic [LINE_W-1:0]  cur_line;
  logic               row_done;
  logic               row_last;
  logic [ADDR_W-1:0]  waddr;

  assign pixels.ready = (state == S_IDLE);
  assign in_fire      = pixels.valid && pixels.ready;
  assign restart      = ({1'b0, in_row} >= n) || ({1'b0, in_col} >= n);
  assign cur_row      = restart ? '0 : in_row;
  assign cur_col      = restart ? '0 : in_col;
  assign cur_line     = restart ? '0 : in_line;
  assign row_done     = (SIZE_W'(cur_col) + 1'b1) >= n;
  assign row_last     = (SIZE_W'(cur_row) + 1'b1) >= n;
  assign waddr        = ADDR_W'(cur_line) * ADDR_W'(MAX_TILE) + ADDR_W'(cur_col);

  // Neighbor of the current tap, its address and its weight.
  logic [COORD_W+1:0] nb_row;
  logic [COORD_W+1:0] nb_col;
  logic               nb_ok;
  logic [LINE_W-1:0]  nb_line;
  logic [ADDR_W-1:0]  raddr;
  logic               col_border;
  logic               col_end;
  logic [PIX_W-1:0]   w_base;
  logic [PIX_W-1:0]   w_fold;
  logic [WEIGHT_W-1:0] w_tap;
  logic               tap_end;

  assign nb_row  = (COORD_W+2)'(em_row) + (COORD_W+2)'(tap_dr) - 1'b1;
  assign nb_col  = (COORD_W+2)'(em_col) + (COORD_W+2)'(tap_dc) - 1'b1;
  assign nb_ok   = (nb_row < (COORD_W+2)'(n)) && (nb_col < (COORD_W+2)'(n));
  assign nb_line = (tap_dr == 2'd0) ? line_prev(em_line) :
                   (tap_dr == 2'd1) ? em_line : line_next(em_line);
  assign raddr   = ADDR_W'(nb_line) * ADDR_W'(MAX_TILE) + ADDR_W'(nb_col[COORD_W-1:0]);
  assign col_end    = (SIZE_W'(em_col) + 1'b1) == n;
  assign col_border = (em_col == '0) || col_end;
  assign tap_end    = (tap_dr == 2'd2) && (tap_dc == 2'd2);

  always_comb begin
    if ((tap_dr == 2'd1) && (tap_dc == 2'd1)) begin
      w_base = coef_center;
    end else if ((tap_dr == 2'd1) || (tap_dc == 2'd1)) begin
      w_base = coef_edge;
    end else begin
      w_base = coef_corner;
    end
    // The spill beside the tile folds back onto the border column.
    if ((tap_dc == 2'd1) && col_border) begin
      w_fold = (tap_dr == 2'd1) ? coef_edge : coef_corner;
    end else begin
      w_fold = '0;
    end
    w_tap = WEIGHT_W'(w_base) + WEIGHT_W'(w_fold);
  end

  // Line store.
  logic [PIX_W-1:0] rdata;

  g3c_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_lines (
    .clk   (clk),
    .we    (in_fire),
    .waddr (waddr),
    .wdata (pixels.data.pixel),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Shared multiply-accumulate unit.
  mac_ctrl_t        mac_ctrl;
  logic [PIX_W-1:0] mac_sample;
  logic [ACC_W-1:0] acc;

  assign mac_ctrl.en    = tap_v;
  assign mac_ctrl.first = tap_first;
  assign mac_sample     = tap_ok ? rdata : '0;

  g3c_mac u_mac (
    .clk    (clk),
    .ctrl   (mac_ctrl),
    .weight (tap_w),
    .sample (mac_sample),
    .acc    (acc)
  );

  // Truncate to Q2.16 and saturate.
  logic [ACC_W-FRAC_W-1:0] acc_q;
  result_t                 out_next;
  logic                    out_load;

  assign acc_q             = acc[ACC_W-1:FRAC_W];
  assign out_next.smoothed = (acc_q > SAT_MAX) ? SAT_MAX[SMO_W-1:0] : acc_q[SMO_W-1:0];
  assign out_next.out_row  = em_row;
  assign out_next.out_col  = em_col;
  assign out_next.last     = col_end && !em_more;
  assign out_load          = (state == S_PUT) && (!out_valid || results.ready);

  assign results.valid = out_valid;
  assign results.data  = out_data;

  // Sequencer, configuration and registered outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      tile_size   <= TILE_SIZE_RST;
      coef_center <= COEF_CENTER_RST;
      coef_edge   <= COEF_EDGE_RST;
      coef_corner <= COEF_CORNER_RST;
      in_row      <= '0;
      in_col      <= '0;
      in_line     <= '0;
      tap_v       <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      // Register writes.
      if (write_en) begin
        case (write_index)
          REG_TILE_SIZE:   tile_size   <= write_data[SIZE_W-1:0];
          REG_COEF_CENTER: coef_center <= write_data[PIX_W-1:0];
          REG_COEF_EDGE:   coef_edge   <= write_data[PIX_W-1:0];
          REG_COEF_CORNER: coef_corner <= write_data[PIX_W-1:0];
          default: ;
        endcase
      end

      // Output register empties when the receiver takes the result and no
      // new result is loaded in the same cycle.
      if (results.valid && results.ready && !out_load) begin
        out_valid <= 1'b0;
      end

      // A tap issued now reaches the multiply-accumulate unit next cycle.
      tap_v <= (state == S_ISSUE);

      case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (!row_done) begin
              in_row  <= cur_row;
              in_line <= cur_line;
              in_col  <= cur_col + 1'b1;
            end else begin
              in_col <= '0;
              if (row_last) begin
                in_row  <= '0;
                in_line <= '0;
              end else begin
                in_row  <= cur_row + 1'b1;
                in_line <= line_next(cur_line);
              end
              // A finished row other than the first releases the row above it.
              if (cur_row != '0) begin
                em_row  <= cur_row - 1'b1;
                em_line <= line_prev(cur_line);
                em_more <= row_last;
                em_col  <= '0;
                tap_dr  <= '0;
                tap_dc  <= '0;
                state   <= S_ISSUE;
              end
            end
          end
        end

        S_ISSUE: begin
          tap_first <= (tap_dr == 2'd0) && (tap_dc == 2'd0);
          tap_ok    <= nb_ok;
          tap_w     <= w_tap;
          if (tap_dc == 2'd2) begin
            tap_dc <= '0;
            tap_dr <= tap_dr + 1'b1;
          end else begin
            tap_dc <= tap_dc + 1'b1;
          end
          if (tap_end) begin
            state <= S_DRAIN;
          end
        end

        S_DRAIN: begin
          state <= S_PUT;
        end

        S_PUT: begin
          if (out_load) begin
            out_valid <= 1'b1;
            out_data  <= out_next;
            tap_dr    <= '0;
            tap_dc    <= '0;
            if (!col_end) begin
              em_col <= em_col + 1'b1;
              state  <= S_ISSUE;
            end else if (em_more) begin
              em_col  <= '0;
              em_row  <= em_row + 1'b1;
              em_line <= line_next(em_line);
              em_more <= 1'b0;
              state   <= S_ISSUE;
            end else begin
              state <= S_IDLE;
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // A completed row below the first one starts the output sequence.
  a_row_starts_output: assert property (@(posedge clk) disable iff (rst)
    (in_fire && row_done && (cur_row != '0)) |=> (state == S_ISSUE))
    else $error("row end did not start the output sequence");

  // The last result of a run lies in the last column and ends the run.
  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (out_load && out_next.last) |-> col_end ##1 (state == S_IDLE))
    else $error("last result out of place");

  // The multiply-accumulate unit is fed only while taps are in flight.
  a_mac_in_flight: assert property (@(posedge clk) disable iff (rst)
    tap_v |-> ((state == S_ISSUE) || (state == S_DRAIN)))
    else $error("tap outside the tap sequence");

  // No pixel is taken while a result is being built.
  a_busy_no_input: assert property (@(posedge clk) disable iff (rst)
    (state == S_ISSUE) |=> !in_fire || (state == S_IDLE))
    else $error("pixel taken during output");
endmodule
